@@ hdl/itt_pkg.sv @@
// Shared types, character codes and helper functions for the INI text tokenizer.
package itt_pkg;

  // Counter widths; line and column stop at their all-ones value.
  localparam int unsigned LINE_BITS   = 16;
  localparam int unsigned COLUMN_BITS = 12;

  // Widths of the reported position fields.
  localparam int unsigned POS_LINE_W   = 16;
  localparam int unsigned POS_COLUMN_W = 12;

  // Character codes.
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  // Directive name lengths.
  localparam logic [3:0] INC_LEN = 4'd7;
  localparam logic [3:0] TRY_LEN = 4'd10;

  // Lexer modes, one-hot.
  typedef enum logic [5:0] {
    MODE_IDLE      = 6'b000001,
    MODE_COMMENT   = 6'b000010,
    MODE_SECTION   = 6'b000100,
    MODE_WORD      = 6'b001000,
    MODE_QUOTED    = 6'b010000,
    MODE_DIRECTIVE = 6'b100000
  } mode_e;

  typedef enum logic [3:0] {
    START_NONE      = 4'd0,
    START_SECTION   = 4'd1,
    START_WORD      = 4'd2,
    START_QUOTED    = 4'd3,
    START_ASSIGN    = 4'd4,
    START_LPAREN    = 4'd5,
    START_RPAREN    = 4'd6,
    START_COMMA     = 4'd7,
    START_DIRECTIVE = 4'd8
  } start_e;

  typedef enum logic [2:0] {
    CLOSE_NONE       = 3'd0,
    CLOSE_SECTION    = 3'd1,
    CLOSE_WORD       = 3'd2,
    CLOSE_QUOTED     = 3'd3,
    CLOSE_INCLUDE    = 3'd4,
    CLOSE_TRYINCLUDE = 3'd5
  } close_e;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_SECT_NL     = 3'd1,
    ERR_SECT_RSVD   = 3'd2,
    ERR_SECT_EOF    = 3'd3,
    ERR_SECT_EMPTY  = 3'd4,
    ERR_OPEN_QUOTE  = 3'd5,
    ERR_BAD_DIR     = 3'd6,
    ERR_STRAY       = 3'd7
  } err_e;

  // Characters that end a word and may not appear in a section name.
  function automatic logic is_rsvd_char(input logic [7:0] b);
    return (b == CH_LPAREN) || (b == CH_RPAREN) || (b == CH_COMMA) ||
           (b == CH_SQUOTE) || (b == CH_DQUOTE) || (b == CH_LBRACK) ||
           (b == CH_RBRACK) || (b == CH_AT) || (b == CH_HASH) || (b == CH_EQUALS);
  endfunction

  function automatic logic is_wspace(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
           (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
  endfunction

  // Letter of "include" at a given position.
  function automatic logic [7:0] inc_char(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = "i";
      4'd1:    c = "n";
      4'd2:    c = "c";
      4'd3:    c = "l";
      4'd4:    c = "u";
      4'd5:    c = "d";
      4'd6:    c = "e";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Letter of "tryinclude" at a given position.
  function automatic logic [7:0] try_char(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = "t";
      4'd1:    c = "r";
      4'd2:    c = "y";
      4'd3:    c = "i";
      4'd4:    c = "n";
      4'd5:    c = "c";
      4'd6:    c = "l";
      4'd7:    c = "u";
      4'd8:    c = "d";
      4'd9:    c = "e";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Kind of directive that closes here, or none if the name is incomplete.
  function automatic close_e dir_close(input logic [1:0] match, input logic [3:0] pos);
    close_e k;
    k = CLOSE_NONE;
    if (match[0] && (pos == INC_LEN)) begin
      k = CLOSE_INCLUDE;
    end else if (match[1] && (pos == TRY_LEN)) begin
      k = CLOSE_TRYINCLUDE;
    end
    return k;
  endfunction

endpackage

@@ hdl/ini_text_tokenizer_core.sv @@
// Top level of the INI text tokenizer: input register, lexer step and result register.
//
// The tokenizer takes one text byte per word and returns one result word for it, one
// word per cycle sustained while the output side is ready. A word passes through an
// input register, then the lexer step (mode, counters and directive matcher, all one
// shallow stage), then the result register, where its result waits until the output
// side takes it. The input register lets one more word be taken while a result waits
// at the output. The end flag reports the document's final status and returns every
// counter and mode to its reset value.
module ini_text_tokenizer_core
  import itt_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              in_byte_i,
  input  logic                    end_of_input_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [3:0]              start_kind_o,
  output logic                    value_valid_o,
  output logic [7:0]              value_byte_o,
  output logic [2:0]              closed_kind_o,
  output logic [POS_LINE_W-1:0]   pos_line_o,
  output logic [POS_COLUMN_W-1:0] pos_column_o,
  output logic [2:0]              error_code_o,
  output logic                    doc_done_o
);

  localparam logic [LINE_BITS-1:0]   LINE_TOP  = '1;
  localparam logic [COLUMN_BITS-1:0] COL_TOP   = '1;
  localparam logic [LINE_BITS-1:0]   LINE_INIT = LINE_BITS'(1);
  localparam logic [31:0] POS_LINE_TOP   = 32'((64'd1 << POS_LINE_W) - 64'd1);
  localparam logic [31:0] POS_COLUMN_TOP = 32'((64'd1 << POS_COLUMN_W) - 64'd1);

  // Input register.
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       end_q;

  // Result register.
  logic                    out_valid_q;
  start_e                  sk_q;
  logic                    vv_q;
  logic [7:0]              vb_q;
  close_e                  ck_q;
  logic [POS_LINE_W-1:0]   pl_q;
  logic [POS_COLUMN_W-1:0] pc_q;
  err_e                    err_q;
  logic                    done_q;

  // Lexer state.
  mode_e                  mode_q, mode_d;
  logic                   qdouble_q, qdouble_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [COLUMN_BITS-1:0] col_q, col_d;
  logic                   sect_ne_q, sect_ne_d;
  logic [3:0]             dpos_q, dpos_d;
  logic [1:0]             dmatch_q, dmatch_d;
  err_e                   held_q, held_d;

  // Step outputs.
  start_e                  sk;
  logic                    vv;
  logic [7:0]              vb;
  close_e                  ck;
  err_e                    err;
  logic                    done;
  logic [POS_LINE_W-1:0]   pl;
  logic [POS_COLUMN_W-1:0] pc;

  logic        advance;
  logic        fire;
  logic [31:0] line_wide;
  logic [31:0] col_wide;

  // The input register moves on whenever the result register is free or being emptied.
  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  // Reported position, clipped to the width of the output fields.
  assign line_wide = 32'(line_q);
  assign col_wide  = 32'(col_q);
  assign pl = (line_wide > POS_LINE_TOP)   ? '1 : line_wide[POS_LINE_W-1:0];
  assign pc = (col_wide  > POS_COLUMN_TOP) ? '1 : col_wide[POS_COLUMN_W-1:0];

  // Lexer step for the word in the input register.
  always_comb begin
    logic       redo;
    logic       col_inc;
    logic       line_inc;
    logic       col_clr;
    logic [1:0] m;

    sk        = START_NONE;
    vv        = 1'b0;
    vb        = 8'h00;
    ck        = CLOSE_NONE;
    err       = ERR_NONE;
    done      = 1'b0;
    mode_d    = mode_q;
    qdouble_d = qdouble_q;
    line_d    = line_q;
    col_d     = col_q;
    sect_ne_d = sect_ne_q;
    dpos_d    = dpos_q;
    dmatch_d  = dmatch_q;
    held_d    = held_q;
    redo      = 1'b0;
    col_inc   = 1'b0;
    line_inc  = 1'b0;
    col_clr   = 1'b0;
    m         = 2'b00;

    if (end_q) begin
      // End of document: report what is left open, then return to reset values.
      if (held_q != ERR_NONE) begin
        err = held_q;
      end else if (mode_q == MODE_WORD) begin
        ck = CLOSE_WORD;
      end else if (mode_q == MODE_DIRECTIVE) begin
        ck = dir_close(dmatch_q, dpos_q);
        if (ck == CLOSE_NONE) begin
          err = ERR_BAD_DIR;
        end
      end else if (mode_q == MODE_SECTION) begin
        err = ERR_SECT_EOF;
      end else if (mode_q == MODE_QUOTED) begin
        err = ERR_OPEN_QUOTE;
      end
      done      = 1'b1;
      mode_d    = MODE_IDLE;
      qdouble_d = 1'b0;
      line_d    = LINE_INIT;
      col_d     = '0;
      sect_ne_d = 1'b0;
      dpos_d    = 4'd0;
      dmatch_d  = 2'b11;
      held_d    = ERR_NONE;
    end else if (held_q != ERR_NONE) begin
      err = held_q;
    end else begin
      // Per-mode handling of the byte.
      unique case (mode_q)
        MODE_COMMENT: begin
          if (byte_q == CH_LF) begin
            mode_d = MODE_IDLE;
            redo   = 1'b1;
          end else begin
            col_inc = 1'b1;
          end
        end
        MODE_SECTION: begin
          if (byte_q == CH_RBRACK) begin
            if (sect_ne_q) begin
              ck     = CLOSE_SECTION;
              mode_d = MODE_IDLE;
            end else begin
              err = ERR_SECT_EMPTY;
            end
          end else if (byte_q == CH_LF) begin
            err = ERR_SECT_NL;
          end else if (is_rsvd_char(byte_q)) begin
            err = ERR_SECT_RSVD;
          end else begin
            vv        = 1'b1;
            vb        = byte_q;
            sect_ne_d = 1'b1;
            col_inc   = 1'b1;
          end
        end
        MODE_QUOTED: begin
          if (byte_q == (qdouble_q ? CH_DQUOTE : CH_SQUOTE)) begin
            ck     = CLOSE_QUOTED;
            mode_d = MODE_IDLE;
          end else begin
            vv      = 1'b1;
            vb      = byte_q;
            col_inc = 1'b1;
          end
        end
        MODE_WORD: begin
          if (is_wspace(byte_q) || is_rsvd_char(byte_q)) begin
            ck     = CLOSE_WORD;
            mode_d = MODE_IDLE;
            redo   = 1'b1;
          end else begin
            vv      = 1'b1;
            vb      = byte_q;
            col_inc = 1'b1;
          end
        end
        MODE_DIRECTIVE: begin
          if ((byte_q == CH_SPACE) || (byte_q == CH_TAB)) begin
            ck = dir_close(dmatch_q, dpos_q);
            if (ck == CLOSE_NONE) begin
              err = ERR_BAD_DIR;
            end else begin
              mode_d = MODE_IDLE;
              redo   = 1'b1;
            end
          end else begin
            m[0] = dmatch_q[0] && (dpos_q < INC_LEN) && (byte_q == inc_char(dpos_q));
            m[1] = dmatch_q[1] && (dpos_q < TRY_LEN) && (byte_q == try_char(dpos_q));
            dmatch_d = m;
            if (m == 2'b00) begin
              err = ERR_BAD_DIR;
            end else begin
              dpos_d  = dpos_q + 4'd1;
              col_inc = 1'b1;
            end
          end
        end
        default: begin
          mode_d = MODE_IDLE;
          redo   = 1'b1;
        end
      endcase

      // Idle handling, also for a byte that just ended a word, comment or directive.
      if (redo && (err == ERR_NONE)) begin
        unique case (byte_q)
          CH_LF: begin
            line_inc = 1'b1;
            col_clr  = 1'b1;
          end
          CH_SPACE, CH_TAB: begin
            col_inc = 1'b1;
          end
          CH_EQUALS: begin
            sk      = START_ASSIGN;
            col_inc = 1'b1;
          end
          CH_LPAREN: begin
            sk      = START_LPAREN;
            col_inc = 1'b1;
          end
          CH_RPAREN: begin
            sk      = START_RPAREN;
            col_inc = 1'b1;
          end
          CH_COMMA: begin
            sk      = START_COMMA;
            col_inc = 1'b1;
          end
          CH_HASH: begin
            mode_d  = MODE_COMMENT;
            col_inc = 1'b1;
          end
          CH_LBRACK: begin
            sk        = START_SECTION;
            mode_d    = MODE_SECTION;
            sect_ne_d = 1'b0;
          end
          CH_AT: begin
            sk       = START_DIRECTIVE;
            mode_d   = MODE_DIRECTIVE;
            dpos_d   = 4'd0;
            dmatch_d = 2'b11;
          end
          CH_SQUOTE, CH_DQUOTE: begin
            sk        = START_QUOTED;
            mode_d    = MODE_QUOTED;
            qdouble_d = (byte_q == CH_DQUOTE);
          end
          CH_RBRACK, CH_CR, CH_VT, CH_FF: begin
            err = ERR_STRAY;
          end
          default: begin
            sk      = START_WORD;
            vv      = 1'b1;
            vb      = byte_q;
            mode_d  = MODE_WORD;
            col_inc = 1'b1;
          end
        endcase
      end

      // Counters, which saturate at their top value.
      if (line_inc && (line_q < LINE_TOP)) begin
        line_d = line_q + LINE_BITS'(1);
      end
      if (col_clr) begin
        col_d = '0;
      end else if (col_inc && (col_q < COL_TOP)) begin
        col_d = col_q + COLUMN_BITS'(1);
      end

      // An error clears the token fields and freezes everything but the held code.
      if (err != ERR_NONE) begin
        held_d    = err;
        sk        = START_NONE;
        vv        = 1'b0;
        vb        = 8'h00;
        ck        = CLOSE_NONE;
        mode_d    = mode_q;
        qdouble_d = qdouble_q;
        line_d    = line_q;
        col_d     = col_q;
        sect_ne_d = sect_ne_q;
        dpos_d    = dpos_q;
        dmatch_d  = dmatch_q;
      end
    end
  end

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
      end_q  <= end_of_input_i;
    end
  end

  // Lexer state, updated as each word moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      qdouble_q <= 1'b0;
      line_q    <= LINE_INIT;
      col_q     <= '0;
      sect_ne_q <= 1'b0;
      dpos_q    <= 4'd0;
      dmatch_q  <= 2'b11;
      held_q    <= ERR_NONE;
    end else if (fire) begin
      mode_q    <= mode_d;
      qdouble_q <= qdouble_d;
      line_q    <= line_d;
      col_q     <= col_d;
      sect_ne_q <= sect_ne_d;
      dpos_q    <= dpos_d;
      dmatch_q  <= dmatch_d;
      held_q    <= held_d;
    end
  end

  // Result register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      sk_q   <= sk;
      vv_q   <= vv;
      vb_q   <= vb;
      ck_q   <= ck;
      pl_q   <= pl;
      pc_q   <= pc;
      err_q  <= err;
      done_q <= done;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign start_kind_o  = sk_q;
  assign value_valid_o = vv_q;
  assign value_byte_o  = vb_q;
  assign closed_kind_o = ck_q;
  assign pos_line_o    = pl_q;
  assign pos_column_o  = pc_q;
  assign error_code_o  = err_q;
  assign doc_done_o    = done_q;

endmodule

@@ tb/tb_ini_text_tokenizer_core.sv @@
// Self-checking testbench for the INI text tokenizer core.
module tb_ini_text_tokenizer_core;
  import itt_pkg::*;

  // Cycles without any accepted word or taken result before the run is abandoned.
  localparam int STALL_LIMIT = 1000;
  // Length of the long output hold-off that fills the block.
  localparam int HOLD_CYCLES = 80;

  // One expected result word, field by field.
  typedef struct packed {
    start_e                  start;
    logic                    vv;
    logic [7:0]              vb;
    close_e                  close;
    logic [POS_LINE_W-1:0]   line;
    logic [POS_COLUMN_W-1:0] col;
    err_e                    err;
    logic                    done;
  } tok_result_t;

  // One input word, with an optional result typed in by hand.
  typedef struct packed {
    logic [7:0]  b;
    logic        eoi;
    logic        pin;
    tok_result_t want;
  } drv_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  in_byte_i;
  logic        end_of_input_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [3:0]  start_kind_o;
  logic        value_valid_o;
  logic [7:0]  value_byte_o;
  logic [2:0]  closed_kind_o;
  logic [15:0] pos_line_o;
  logic [11:0] pos_column_o;
  logic [2:0]  error_code_o;
  logic        doc_done_o;

  // Predictor state.
  mode_e                  lex_mode;
  logic                   quote_dq;
  logic [LINE_BITS-1:0]   line_cnt;
  logic [COLUMN_BITS-1:0] col_cnt;
  logic                   sect_nonempty;
  logic [3:0]             dir_pos;
  logic [1:0]             dir_match;
  err_e                   held_err;
  string                  kw_inc = "include";
  string                  kw_try = "tryinclude";

  tok_result_t results_due [$];
  drv_row_t    words_sent [$];
  drv_row_t    directed_rows [27];

  bit       idle_on;
  bit       hold_req;
  int       fail_count;
  int       words_in;
  int       results_checked;
  int       docs_done;
  bit [7:0] err_seen;

  ini_text_tokenizer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .start_kind_o   (start_kind_o),
    .value_valid_o  (value_valid_o),
    .value_byte_o   (value_byte_o),
    .closed_kind_o  (closed_kind_o),
    .pos_line_o     (pos_line_o),
    .pos_column_o   (pos_column_o),
    .error_code_o   (error_code_o),
    .doc_done_o     (doc_done_o)
  );

  // Clock, period 12.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Characters that end a word and are refused in a section name.
  function automatic logic rsvd_char(input logic [7:0] b);
    return (b == CH_LPAREN) || (b == CH_RPAREN) || (b == CH_COMMA) || (b == CH_SQUOTE) ||
           (b == CH_DQUOTE) || (b == CH_LBRACK) || (b == CH_RBRACK) || (b == CH_AT) ||
           (b == CH_HASH) || (b == CH_EQUALS);
  endfunction

  function automatic logic word_stop(input logic [7:0] b);
    return rsvd_char(b) || (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
           (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
  endfunction

  function automatic void clear_lexer();
    lex_mode      = MODE_IDLE;
    quote_dq      = 1'b0;
    line_cnt      = 1;
    col_cnt       = '0;
    sect_nonempty = 1'b0;
    dir_pos       = '0;
    dir_match     = 2'b11;
    held_err      = ERR_NONE;
  endfunction

  function automatic void bump_column();
    if (col_cnt != '1) col_cnt++;
  endfunction

  // Directive kind that a name of the current length completes, if any.
  function automatic close_e dir_kind();
    if (dir_match[0] && (dir_pos == INC_LEN)) return CLOSE_INCLUDE;
    if (dir_match[1] && (dir_pos == TRY_LEN)) return CLOSE_TRYINCLUDE;
    return CLOSE_NONE;
  endfunction

  function automatic tok_result_t fixed_result(input start_e s, input logic vv,
                                               input logic [7:0] vb, input close_e c,
                                               input int ln, input int cl, input err_e e,
                                               input logic d);
    tok_result_t r;
    r.start = s;
    r.vv    = vv;
    r.vb    = vb;
    r.close = c;
    r.line  = ln[POS_LINE_W-1:0];
    r.col   = cl[POS_COLUMN_W-1:0];
    r.err   = e;
    r.done  = d;
    return r;
  endfunction

  // Works out the result word for one input word and advances the lexer state.
  function automatic tok_result_t tokenize_byte(input logic [7:0] b, input logic eoi);
    tok_result_t r;
    logic        redo;
    logic [1:0]  m;
    r = fixed_result(START_NONE, 1'b0, 8'h00, CLOSE_NONE, int'(line_cnt), int'(col_cnt),
                     ERR_NONE, 1'b0);
    redo = 1'b0;

    // The end word closes whatever is open, reports, and resets everything.
    if (eoi) begin
      if (held_err != ERR_NONE) begin
        r.err = held_err;
      end else begin
        case (lex_mode)
          MODE_WORD: r.close = CLOSE_WORD;
          MODE_DIRECTIVE: begin
            r.close = dir_kind();
            if (r.close == CLOSE_NONE) r.err = ERR_BAD_DIR;
          end
          MODE_SECTION: r.err = ERR_SECT_EOF;
          MODE_QUOTED: r.err = ERR_OPEN_QUOTE;
          default: ;
        endcase
      end
      r.done = 1'b1;
      clear_lexer();
      return r;
    end

    if (held_err != ERR_NONE) begin
      r.err = held_err;
      return r;
    end

    // Mode-specific handling; some bytes end the token and are then taken as in idle.
    case (lex_mode)
      MODE_COMMENT: begin
        if (b == CH_LF) begin
          lex_mode = MODE_IDLE;
          redo = 1'b1;
        end else begin
          bump_column();
        end
      end
      MODE_SECTION: begin
        if (b == CH_RBRACK) begin
          if (sect_nonempty) begin
            r.close = CLOSE_SECTION;
            lex_mode = MODE_IDLE;
          end else begin
            r.err = ERR_SECT_EMPTY;
          end
        end else if (b == CH_LF) begin
          r.err = ERR_SECT_NL;
        end else if (rsvd_char(b)) begin
          r.err = ERR_SECT_RSVD;
        end else begin
          r.vv = 1'b1;
          r.vb = b;
          sect_nonempty = 1'b1;
          bump_column();
        end
      end
      MODE_QUOTED: begin
        if (b == (quote_dq ? CH_DQUOTE : CH_SQUOTE)) begin
          r.close = CLOSE_QUOTED;
          lex_mode = MODE_IDLE;
        end else begin
          r.vv = 1'b1;
          r.vb = b;
          bump_column();
        end
      end
      MODE_WORD: begin
        if (word_stop(b)) begin
          r.close = CLOSE_WORD;
          lex_mode = MODE_IDLE;
          redo = 1'b1;
        end else begin
          r.vv = 1'b1;
          r.vb = b;
          bump_column();
        end
      end
      MODE_DIRECTIVE: begin
        if ((b == CH_SPACE) || (b == CH_TAB)) begin
          r.close = dir_kind();
          if (r.close == CLOSE_NONE) begin
            r.err = ERR_BAD_DIR;
          end else begin
            lex_mode = MODE_IDLE;
            redo = 1'b1;
          end
        end else begin
          m = 2'b00;
          if (dir_match[0] && (dir_pos < INC_LEN) && (b == 8'(kw_inc[dir_pos]))) m[0] = 1'b1;
          if (dir_match[1] && (dir_pos < TRY_LEN) && (b == 8'(kw_try[dir_pos]))) m[1] = 1'b1;
          dir_match = m;
          if (m == 2'b00) begin
            r.err = ERR_BAD_DIR;
          end else begin
            dir_pos++;
            bump_column();
          end
        end
      end
      default: begin
        lex_mode = MODE_IDLE;
        redo = 1'b1;
      end
    endcase

    // Idle handling: token starts, skipped blanks and stray characters.
    if (redo && (r.err == ERR_NONE)) begin
      case (b)
        CH_LF: begin
          if (line_cnt != '1) line_cnt++;
          col_cnt = '0;
        end
        CH_SPACE, CH_TAB: bump_column();
        CH_EQUALS: begin
          r.start = START_ASSIGN;
          bump_column();
        end
        CH_LPAREN: begin
          r.start = START_LPAREN;
          bump_column();
        end
        CH_RPAREN: begin
          r.start = START_RPAREN;
          bump_column();
        end
        CH_COMMA: begin
          r.start = START_COMMA;
          bump_column();
        end
        CH_HASH: begin
          lex_mode = MODE_COMMENT;
          bump_column();
        end
        CH_LBRACK: begin
          r.start = START_SECTION;
          lex_mode = MODE_SECTION;
          sect_nonempty = 1'b0;
        end
        CH_AT: begin
          r.start = START_DIRECTIVE;
          lex_mode = MODE_DIRECTIVE;
          dir_pos = '0;
          dir_match = 2'b11;
        end
        CH_SQUOTE, CH_DQUOTE: begin
          r.start = START_QUOTED;
          lex_mode = MODE_QUOTED;
          quote_dq = (b == CH_DQUOTE);
        end
        CH_RBRACK, CH_CR, CH_VT, CH_FF: r.err = ERR_STRAY;
        default: begin
          r.start = START_WORD;
          r.vv = 1'b1;
          r.vb = b;
          lex_mode = MODE_WORD;
          bump_column();
        end
      endcase
    end

    // An error blanks the token fields and is held until the end word.
    if (r.err != ERR_NONE) begin
      held_err = r.err;
      r.start  = START_NONE;
      r.vv     = 1'b0;
      r.vb     = 8'h00;
      r.close  = CLOSE_NONE;
    end
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      note_mismatch($sformatf("%s got %0h, expected %0h, result %0d", name, got, want,
                              results_checked));
    end
  endtask

  // Offers one word, after a random idle burst when idling is on, until it is taken.
  task automatic send_word(input drv_row_t row);
    int gap;
    gap = (idle_on && ($urandom_range(0, 3) == 0)) ? $urandom_range(1, 18) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    words_sent.insert(words_sent.size(), row);
    in_valid_i     <= 1'b1;
    in_byte_i      <= row.b;
    end_of_input_i <= row.eoi;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic put_byte(input logic [7:0] b);
    drv_row_t row;
    row   = '0;
    row.b = b;
    send_word(row);
  endtask

  task automatic end_document();
    drv_row_t row;
    row     = '0;
    row.b   = 8'($urandom_range(0, 255));
    row.eoi = 1'b1;
    send_word(row);
  endtask

  task automatic put_name(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(8'(s[i]));
  endtask

  // Random byte fit for a word, or with blanks allowed, for a section or quote.
  function automatic logic [7:0] pick_plain(input logic allow_space);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (allow_space ? (rsvd_char(b) || (b == CH_LF)) : word_stop(b));
    return b;
  endfunction

  // Stops offering and waits until every result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (results_due.size() != 0);
  endtask

  // One document of well-formed tokens with random content, sometimes with a broken one.
  task automatic random_document();
    int         n_tok;
    int         broken_at;
    logic       finish_now;
    logic [7:0] q;
    logic [7:0] b;
    n_tok      = $urandom_range(3, 12);
    broken_at  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_tok - 1) : -1;
    finish_now = 1'b0;
    for (int t = 0; (t < n_tok) && !finish_now; t++) begin
      if (t == broken_at) begin
        case ($urandom_range(0, 7))
          0: begin
            put_byte(CH_LBRACK);
            put_byte(pick_plain(1'b1));
            put_byte(CH_LF);
          end
          1: begin
            put_byte(CH_LBRACK);
            put_byte(pick_plain(1'b1));
            do b = 8'($urandom_range(0, 255)); while (!rsvd_char(b) || (b == CH_RBRACK));
            put_byte(b);
          end
          2: begin
            put_byte(CH_LBRACK);
            put_byte(CH_RBRACK);
          end
          3: begin
            case ($urandom_range(0, 3))
              0: put_byte(CH_RBRACK);
              1: put_byte(CH_CR);
              2: put_byte(CH_VT);
              default: put_byte(CH_FF);
            endcase
          end
          4: begin
            put_byte(CH_AT);
            put_name("in");
            put_byte(8'($urandom_range(0, 255)));
          end
          5: begin
            put_byte(CH_AT);
            put_name($urandom_range(0, 1) ? "try" : "incl");
            if ($urandom_range(0, 1)) finish_now = 1'b1;
            else put_byte(CH_TAB);
          end
          6: begin
            put_byte(CH_LBRACK);
            put_byte(pick_plain(1'b1));
            finish_now = 1'b1;
          end
          default: begin
            put_byte($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
            put_byte(pick_plain(1'b1));
            finish_now = 1'b1;
          end
        endcase
      end else begin
        case ($urandom_range(0, 11))
          0, 1: begin
            repeat ($urandom_range(1, 6)) put_byte(pick_plain(1'b0));
            case ($urandom_range(0, 3))
              0: put_byte(CH_SPACE);
              1: put_byte(CH_TAB);
              2: put_byte(CH_LF);
              default: ;
            endcase
          end
          2: begin
            put_byte(CH_LBRACK);
            repeat ($urandom_range(1, 5)) put_byte(pick_plain(1'b1));
            put_byte(CH_RBRACK);
            put_byte(CH_LF);
          end
          3: begin
            q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
            put_byte(q);
            repeat ($urandom_range(0, 6)) begin
              do b = 8'($urandom_range(0, 255)); while (b == q);
              put_byte(b);
            end
            put_byte(q);
          end
          4: put_byte(CH_EQUALS);
          5: put_byte(CH_LPAREN);
          6: put_byte(CH_RPAREN);
          7: put_byte(CH_COMMA);
          8: begin
            put_byte(CH_HASH);
            repeat ($urandom_range(0, 6)) begin
              do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
              put_byte(b);
            end
            put_byte(CH_LF);
          end
          9: begin
            put_byte(CH_AT);
            put_name($urandom_range(0, 1) ? "include" : "tryinclude");
            if ($urandom_range(0, 3) == 0) finish_now = 1'b1;
            else put_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
          end
          10: begin
            repeat ($urandom_range(1, 3)) begin
              case ($urandom_range(0, 2))
                0: put_byte(CH_SPACE);
                1: put_byte(CH_TAB);
                default: put_byte(CH_LF);
              endcase
            end
          end
          default: put_byte(8'($urandom_range(0, 255)));
        endcase
      end
    end
    end_document();
  endtask

  // Output side: random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (idle_on && ($urandom_range(0, 7) == 0)) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Predicts on every accepted word and checks every accepted result.
  always @(posedge clk_i) begin
    drv_row_t    row;
    tok_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        row  = words_sent.pop_front();
        want = tokenize_byte(in_byte_i, end_of_input_i);
        if (row.pin) want = row.want;
        err_seen[want.err] = 1'b1;
        results_due.insert(results_due.size(), want);
        words_in++;
      end
      if (out_valid_o && out_ready_i) begin
        if (results_due.size() == 0) begin
          note_mismatch($sformatf("result with no word outstanding, line %0d column %0d",
                                  pos_line_o, pos_column_o));
        end else begin
          want = results_due.pop_front();
          check_field("start_kind", start_kind_o, want.start);
          check_field("value_valid", value_valid_o, want.vv);
          check_field("value_byte", value_byte_o, want.vb);
          check_field("closed_kind", closed_kind_o, want.close);
          check_field("pos_line", pos_line_o, want.line);
          check_field("pos_column", pos_column_o, want.col);
          check_field("error_code", error_code_o, want.err);
          check_field("doc_done", doc_done_o, want.done);
          if (want.done) docs_done++;
          results_checked++;
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall = 0;
      else stall++;
    end
    $display("Watchdog expired after %0d idle cycles, %0d results still due", STALL_LIMIT,
             results_due.size());
    $display("TB_ERROR");
    $finish;
  end

  // Main sequence: reset, directed table, random documents, a final part without idling.
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_byte_i      = 8'h00;
    end_of_input_i = 1'b0;
    out_ready_i    = 1'b0;
    idle_on        = 1'b1;
    hold_req       = 1'b0;
    fail_count     = 0;
    words_in       = 0;
    results_checked = 0;
    docs_done      = 0;
    err_seen       = '0;
    clear_lexer();

    // Stray bracket straight after reset, then a document using every token kind.
    directed_rows = '{
      '{CH_RBRACK, 1'b0, 1'b1, fixed_result(START_NONE, 1'b0, 8'h00, CLOSE_NONE, 1, 0,
                                            ERR_STRAY, 1'b0)},
      '{8'h00, 1'b1, 1'b1, fixed_result(START_NONE, 1'b0, 8'h00, CLOSE_NONE, 1, 0,
                                        ERR_STRAY, 1'b1)},
      '{"k", 1'b0, 1'b1, fixed_result(START_WORD, 1'b1, "k", CLOSE_NONE, 1, 0,
                                      ERR_NONE, 1'b0)},
      '{CH_EQUALS, 1'b0, 1'b0, '0},
      '{CH_DQUOTE, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b1, fixed_result(START_NONE, 1'b1, 8'hFF, CLOSE_NONE, 1, 2,
                                        ERR_NONE, 1'b0)},
      '{CH_LF, 1'b0, 1'b0, '0},
      '{CH_DQUOTE, 1'b0, 1'b0, '0},
      '{CH_LPAREN, 1'b0, 1'b0, '0},
      '{CH_COMMA, 1'b0, 1'b0, '0},
      '{CH_RPAREN, 1'b0, 1'b0, '0},
      '{CH_LBRACK, 1'b0, 1'b0, '0},
      '{"s", 1'b0, 1'b0, '0},
      '{CH_RBRACK, 1'b0, 1'b0, '0},
      '{CH_LF, 1'b0, 1'b0, '0},
      '{CH_HASH, 1'b0, 1'b0, '0},
      '{"x", 1'b0, 1'b0, '0},
      '{CH_LF, 1'b0, 1'b0, '0},
      '{CH_AT, 1'b0, 1'b0, '0},
      '{"i", 1'b0, 1'b0, '0},
      '{"n", 1'b0, 1'b0, '0},
      '{"c", 1'b0, 1'b0, '0},
      '{"l", 1'b0, 1'b0, '0},
      '{"u", 1'b0, 1'b0, '0},
      '{"d", 1'b0, 1'b0, '0},
      '{"e", 1'b0, 1'b0, '0},
      '{8'hFF, 1'b1, 1'b1, fixed_result(START_NONE, 1'b0, 8'h00, CLOSE_INCLUDE, 3, 7,
                                        ERR_NONE, 1'b1)}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_word(directed_rows[i]);
    drain_results();

    // Random documents; the fifth is sent against a long output hold-off.
    for (int d = 0; words_in < 480; d++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ((d == 4) || (d == 5)) idle_on = 1'b0;
      if (d == 4) hold_req = 1'b1;
      random_document();
    end
    drain_results();

    // Final part: more random documents with no idling on either side.
    idle_on = 1'b0;
    while (words_in < 550) random_document();
    drain_results();
    repeat (8) @(posedge clk_i);

    if (results_due.size() != 0) begin
      note_mismatch($sformatf("%0d results never arrived", results_due.size()));
    end
    $display("Run: %0d words in %0d documents, %0d results compared, %0d mismatches",
             words_in, docs_done, results_checked, fail_count);
    $display("Error codes reached (bit per code): %b; well-formed and broken documents",
             err_seen);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/itt_pkg.sv
hdl/ini_text_tokenizer_core.sv
tb/tb_ini_text_tokenizer_core.sv
